// ===== hdl/nbe_pkg.sv =====
// ----------------------------------------------------------------------------
// nbe_pkg
// Shared types, constants and the knot generator of the basis evaluator.
// ----------------------------------------------------------------------------
package nbe_pkg;

    localparam int MAX_POINTS    = 32;
    localparam int MAX_ORDER     = 8;
    localparam int FRACTION_BITS = 16;

    localparam int IDX_W   = 5;   // control point index
    localparam int CNT_W   = 6;   // point count, knot index, work index
    localparam int ORD_W   = 4;   // order and level
    localparam int KNOT_W  = 6;   // knot value (integer)
    localparam int T_W     = 22;  // parameter, Q6.16
    localparam int W_W     = 24;  // weight, Q8.16
    localparam int V_W     = 17;  // basis value, Q1.16
    localparam int PROD_W  = W_W + V_W;
    localparam int SUM_W   = 46;
    localparam int REM_W   = SUM_W + 1;
    localparam int DVD_W   = 24;
    localparam int STEP_W  = 5;
    localparam int ACC_W   = DVD_W + 1;
    localparam int WORK_DEPTH = MAX_POINTS + MAX_ORDER;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DAT_W  = 6;

    localparam logic [V_W-1:0] ONE_VAL = V_W'(1) << FRACTION_BITS;

    localparam logic [CFG_IDX_W-1:0] CFG_ORDER    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KIND     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RATIONAL = 2'd3;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_EVAL = 1'b1;

    typedef struct packed {
        logic [CNT_W-1:0] n;
        logic [CNT_W-1:0] m;
        logic [ORD_W-1:0] k;
        logic             kind;
        logic             rat;
    } t_cfg;

    typedef struct packed {
        logic             wr_weight;
        logic             lat_t;
        logic             ind_wr;
        logic [CNT_W-1:0] raddr;
        logic [CNT_W-1:0] idx;
        logic [ORD_W-1:0] lev;
        logic             term;
        logic             lat_a;
        logic             lat_b;
        logic             acc_clr;
        logic             mul_rec;
        logic             div_rec;
        logic             acc_add;
        logic             wr_work;
        logic             sum_clr;
        logic             mul_w;
        logic             sum_add;
        logic             div_frac;
        logic             out_load;
    } t_cmd;

    typedef struct packed {
        logic term_ok;
        logic div_done;
        logic sum_zero;
    } t_sts;

    // Knot j of the generated vector: j itself for periodic knots, otherwise
    // k zeros, unit steps, and the final value repeated at the end.
    function automatic logic [KNOT_W-1:0] knot_val(input logic [CNT_W-1:0] j,
                                                  input logic [CNT_W-1:0] n,
                                                  input logic [ORD_W-1:0] k,
                                                  input logic kind);
        logic [CNT_W-1:0] mn;
        logic [KNOT_W-1:0] res;
        mn = (j < n) ? j : n;
        if (kind) begin
            res = j;
        end else if (mn >= CNT_W'(k)) begin
            res = mn - CNT_W'(k) + CNT_W'(1);
        end else begin
            res = '0;
        end
        return res;
    endfunction

endpackage

// ===== hdl/nbe_div.sv =====
// ----------------------------------------------------------------------------
// nbe_div
// Serial restoring divider, one quotient bit per cycle, with a preset remainder.
// ----------------------------------------------------------------------------
module nbe_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [nbe_pkg::REM_W-1:0]      i_rem0,
    input  logic [nbe_pkg::DVD_W-1:0]      i_dividend,
    input  logic [nbe_pkg::SUM_W-1:0]      i_divisor,
    input  logic [nbe_pkg::STEP_W-1:0]     i_steps,
    output logic                           o_done,
    output logic [nbe_pkg::DVD_W-1:0]      o_quotient,
    output logic [nbe_pkg::REM_W-1:0]      o_remainder
);

    logic [nbe_pkg::REM_W-1:0]  r_rem, n_rem;
    logic [nbe_pkg::DVD_W-1:0]  r_quo, n_quo;
    logic [nbe_pkg::DVD_W-1:0]  r_dvd, n_dvd;
    logic [nbe_pkg::SUM_W-1:0]  r_den;
    logic [nbe_pkg::STEP_W-1:0] r_cnt, n_cnt;
    logic                       r_busy, n_busy;
    logic                       r_done, n_done;
    logic [nbe_pkg::REM_W-1:0]  w_shift;

    always_comb begin
        w_shift = {r_rem[nbe_pkg::REM_W-2:0], r_dvd[nbe_pkg::DVD_W-1]};
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_dvd   = r_dvd;
        n_cnt   = r_cnt;
        n_busy  = r_busy;
        n_done  = 1'b0;
        if (r_busy) begin
            n_dvd = {r_dvd[nbe_pkg::DVD_W-2:0], 1'b0};
            if (w_shift >= {1'b0, r_den}) begin
                n_rem = w_shift - {1'b0, r_den};
                n_quo = {r_quo[nbe_pkg::DVD_W-2:0], 1'b1};
            end else begin
                n_rem = w_shift;
                n_quo = {r_quo[nbe_pkg::DVD_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - nbe_pkg::STEP_W'(1);
            if (r_cnt == nbe_pkg::STEP_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_rem0;
            r_quo <= '0;
            r_dvd <= i_dividend;
            r_den <= i_divisor;
            r_cnt <= i_steps;
        end else begin
            r_rem <= n_rem;
            r_quo <= n_quo;
            r_dvd <= n_dvd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= i_start ? 1'b1 : n_busy;
            r_done <= n_done;
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

// ===== hdl/nbe_datapath.sv =====
// ----------------------------------------------------------------------------
// nbe_datapath
// Weight and recursion stores, knot logic, shared multiplier and divider.
// ----------------------------------------------------------------------------
module nbe_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  nbe_pkg::t_cfg                 i_cfg,
    input  nbe_pkg::t_cmd                 i_cmd,
    output nbe_pkg::t_sts                 o_sts,
    input  logic [nbe_pkg::IDX_W-1:0]     i_point_index,
    input  logic [nbe_pkg::W_W-1:0]       i_point_weight,
    input  logic [nbe_pkg::T_W-1:0]       i_param_t,
    output logic [nbe_pkg::IDX_W-1:0]     o_basis_index,
    output logic [nbe_pkg::V_W-1:0]       o_basis_value,
    output logic                          o_last_value
);

    localparam int F = nbe_pkg::FRACTION_BITS;

    logic [nbe_pkg::W_W-1:0]   r_weight [nbe_pkg::MAX_POINTS];
    logic [nbe_pkg::V_W-1:0]   r_work   [nbe_pkg::WORK_DEPTH];
    logic [nbe_pkg::W_W-1:0]   r_w_q;
    logic [nbe_pkg::V_W-1:0]   r_work_q;
    logic [nbe_pkg::T_W-1:0]   r_t;
    logic [nbe_pkg::V_W-1:0]   r_a, r_b, r_v;
    logic [nbe_pkg::PROD_W-1:0] r_prod;
    logic [nbe_pkg::KNOT_W-1:0] r_span;
    logic                      r_ok;
    logic [nbe_pkg::ACC_W-1:0] r_acc;
    logic [nbe_pkg::SUM_W-1:0] r_sum;

    logic [nbe_pkg::KNOT_W-1:0] w_kn_i, w_kn_i1, w_kn_il, w_kn_il1, w_kn_m;
    logic [nbe_pkg::T_W-1:0]    w_ua, w_ub, w_lo_next, w_last;
    logic                       w_ind, w_force;
    logic [nbe_pkg::V_W-1:0]    w_vforce, w_sat, w_mul_y, w_frac;
    logic [nbe_pkg::W_W-1:0]    w_mul_x;
    logic [nbe_pkg::KNOT_W-1:0] w_span;
    logic                       w_ok;
    logic [nbe_pkg::PROD_W:0]   w_rnd;
    logic                       w_start;
    logic [nbe_pkg::REM_W-1:0]  w_rem0;
    logic [nbe_pkg::DVD_W-1:0]  w_dvd;
    logic [nbe_pkg::SUM_W-1:0]  w_den;
    logic [nbe_pkg::STEP_W-1:0] w_steps;
    logic                       w_done;
    logic [nbe_pkg::DVD_W-1:0]  w_quo;
    logic [nbe_pkg::REM_W-1:0]  w_rem;
    logic [nbe_pkg::ACC_W-1:0]  w_qr;
    logic                       w_last_idx;

    always_comb begin
        w_kn_i   = nbe_pkg::knot_val(i_cmd.idx, i_cfg.n, i_cfg.k, i_cfg.kind);
        w_kn_i1  = nbe_pkg::knot_val(i_cmd.idx + nbe_pkg::CNT_W'(1), i_cfg.n, i_cfg.k,
                                     i_cfg.kind);
        w_kn_il  = nbe_pkg::knot_val(i_cmd.idx + nbe_pkg::CNT_W'(i_cmd.lev), i_cfg.n,
                                     i_cfg.k, i_cfg.kind);
        w_kn_il1 = nbe_pkg::knot_val(i_cmd.idx + nbe_pkg::CNT_W'(i_cmd.lev)
                                     + nbe_pkg::CNT_W'(1), i_cfg.n, i_cfg.k, i_cfg.kind);
        w_kn_m   = nbe_pkg::knot_val(i_cfg.m, i_cfg.n, i_cfg.k, i_cfg.kind);
        w_ua      = {w_kn_i, F'(0)};
        w_lo_next = {w_kn_i1, F'(0)};
        w_ub      = {w_kn_il1, F'(0)};
        w_last    = {w_kn_m, F'(0)};
        w_ind     = (r_t >= w_ua) && (r_t < w_lo_next);
        w_force   = (r_t == w_last);
        w_last_idx = (i_cmd.idx == i_cfg.n - nbe_pkg::CNT_W'(1));
        w_vforce  = (w_force && w_last_idx) ? nbe_pkg::ONE_VAL : r_work_q;
        w_sat     = (r_acc > nbe_pkg::ACC_W'(nbe_pkg::ONE_VAL)) ? nbe_pkg::ONE_VAL
                                                               : r_acc[nbe_pkg::V_W-1:0];

        // Operands of the one multiplier: a recursion term or a weighting.
        if (i_cmd.mul_w) begin
            w_mul_x = r_w_q;
            w_mul_y = w_vforce;
            w_span  = '0;
            w_ok    = 1'b0;
        end else if (!i_cmd.term) begin
            w_mul_x = nbe_pkg::W_W'(r_t - w_ua);
            w_mul_y = r_a;
            w_span  = w_kn_il - w_kn_i;
            w_ok    = (r_a != '0) && (r_t >= w_ua) && (w_span != '0);
        end else begin
            w_mul_x = nbe_pkg::W_W'(w_ub - r_t);
            w_mul_y = r_b;
            w_span  = w_kn_il1 - w_kn_i1;
            w_ok    = (r_b != '0) && (w_ub >= r_t) && (w_span != '0);
        end

        // Round half up by adding half the divisor before the integer divide.
        w_rnd = {1'b0, r_prod} + ((nbe_pkg::PROD_W + 1)'(r_span) << (F - 1));

        w_start = i_cmd.div_rec || i_cmd.div_frac;
        if (i_cmd.div_frac) begin
            w_rem0  = nbe_pkg::REM_W'(r_prod);
            w_dvd   = '0;
            w_den   = r_sum;
            w_steps = nbe_pkg::STEP_W'(F);
        end else begin
            w_rem0  = '0;
            w_dvd   = w_rnd[F +: nbe_pkg::DVD_W];
            w_den   = nbe_pkg::SUM_W'(r_span);
            w_steps = nbe_pkg::STEP_W'(nbe_pkg::DVD_W);
        end

        w_qr = {1'b0, w_quo};
        if ({w_rem, 1'b0} >= {2'b00, r_sum}) begin
            w_qr = w_qr + nbe_pkg::ACC_W'(1);
        end
        w_frac = (w_qr > nbe_pkg::ACC_W'(nbe_pkg::ONE_VAL)) ? nbe_pkg::ONE_VAL
                                                           : w_qr[nbe_pkg::V_W-1:0];
    end

    nbe_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_start),
        .i_rem0      (w_rem0),
        .i_dividend  (w_dvd),
        .i_divisor   (w_den),
        .i_steps     (w_steps),
        .o_done      (w_done),
        .o_quotient  (w_quo),
        .o_remainder (w_rem)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_weight) begin
            r_weight[i_point_index] <= i_point_weight;
        end
        r_w_q <= r_weight[i_cmd.idx[nbe_pkg::IDX_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ind_wr) begin
            r_work[i_cmd.idx] <= w_ind ? nbe_pkg::ONE_VAL : '0;
        end else if (i_cmd.wr_work) begin
            r_work[i_cmd.idx] <= w_sat;
        end
        r_work_q <= r_work[i_cmd.raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.lat_t) begin
            r_t <= i_param_t;
        end
        if (i_cmd.lat_a) begin
            r_a <= r_work_q;
        end
        if (i_cmd.lat_b) begin
            r_b <= r_work_q;
        end
        if (i_cmd.mul_rec || i_cmd.mul_w) begin
            r_prod <= w_mul_x * w_mul_y;
            r_span <= w_span;
            r_ok   <= w_ok;
        end
        if (i_cmd.mul_w) begin
            r_v <= w_vforce;
        end
        if (i_cmd.acc_clr) begin
            r_acc <= '0;
        end else if (i_cmd.acc_add) begin
            r_acc <= r_acc + nbe_pkg::ACC_W'(w_quo);
        end
        if (i_cmd.sum_clr) begin
            r_sum <= '0;
        end else if (i_cmd.sum_add) begin
            r_sum <= r_sum + nbe_pkg::SUM_W'(r_prod);
        end
        if (i_cmd.out_load) begin
            o_basis_index <= i_cmd.idx[nbe_pkg::IDX_W-1:0];
            o_last_value  <= w_last_idx;
            if (!i_cfg.rat) begin
                o_basis_value <= r_v;
            end else if (r_sum == '0) begin
                o_basis_value <= '0;
            end else begin
                o_basis_value <= w_frac;
            end
        end
    end

    assign o_sts.term_ok  = r_ok;
    assign o_sts.div_done = w_done;
    assign o_sts.sum_zero = (r_sum == '0);

endmodule

// ===== hdl/nbe_ctrl.sv =====
// ----------------------------------------------------------------------------
// nbe_ctrl
// Configuration registers, handshakes and the sequencer of the evaluation.
// ----------------------------------------------------------------------------
module nbe_ctrl (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [nbe_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [nbe_pkg::CFG_DAT_W-1:0]  i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic                           i_func,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output nbe_pkg::t_cfg                  o_cfg,
    output nbe_pkg::t_cmd                  o_cmd,
    input  nbe_pkg::t_sts                  i_sts
);

    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_IND   = 5'd1;
    localparam logic [4:0] ST_RA    = 5'd2;
    localparam logic [4:0] ST_RB    = 5'd3;
    localparam logic [4:0] ST_LB    = 5'd4;
    localparam logic [4:0] ST_MUL   = 5'd5;
    localparam logic [4:0] ST_DIVS  = 5'd6;
    localparam logic [4:0] ST_DIVW  = 5'd7;
    localparam logic [4:0] ST_WR    = 5'd8;
    localparam logic [4:0] ST_SRD   = 5'd9;
    localparam logic [4:0] ST_SMUL  = 5'd10;
    localparam logic [4:0] ST_SACC  = 5'd11;
    localparam logic [4:0] ST_ORD   = 5'd12;
    localparam logic [4:0] ST_OMUL  = 5'd13;
    localparam logic [4:0] ST_ODIVS = 5'd14;
    localparam logic [4:0] ST_ODIVW = 5'd15;
    localparam logic [4:0] ST_OSET  = 5'd16;
    localparam logic [4:0] ST_OWAIT = 5'd17;

    logic [3:0] r_order;
    logic [5:0] r_count;
    logic       r_kind;
    logic       r_rat;

    logic [4:0]                 r_state, n_state;
    logic [nbe_pkg::CNT_W-1:0]  r_idx, n_idx;
    logic [nbe_pkg::ORD_W-1:0]  r_lev, n_lev;
    logic                       r_term, n_term;

    logic [nbe_pkg::CNT_W-1:0]  w_n, w_m;
    logic [nbe_pkg::ORD_W-1:0]  w_k;
    logic                       w_accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order <= 4'd4;
            r_count <= 6'd4;
            r_kind  <= 1'b0;
            r_rat   <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                nbe_pkg::CFG_ORDER:    r_order <= i_cfg_data[3:0];
                nbe_pkg::CFG_COUNT:    r_count <= i_cfg_data;
                nbe_pkg::CFG_KIND:     r_kind  <= i_cfg_data[0];
                nbe_pkg::CFG_RATIONAL: r_rat   <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (r_order < 4'd2) begin
            w_k = 4'd2;
        end else if (r_order > nbe_pkg::ORD_W'(nbe_pkg::MAX_ORDER)) begin
            w_k = nbe_pkg::ORD_W'(nbe_pkg::MAX_ORDER);
        end else begin
            w_k = r_order;
        end
        if (r_count < 6'd2) begin
            w_n = 6'd2;
        end else if (r_count > nbe_pkg::CNT_W'(nbe_pkg::MAX_POINTS)) begin
            w_n = nbe_pkg::CNT_W'(nbe_pkg::MAX_POINTS);
        end else begin
            w_n = r_count;
        end
        w_m = w_n + nbe_pkg::CNT_W'(w_k) - nbe_pkg::CNT_W'(1);
    end

    assign o_cfg.n    = w_n;
    assign o_cfg.m    = w_m;
    assign o_cfg.k    = w_k;
    assign o_cfg.kind = r_kind;
    assign o_cfg.rat  = r_rat;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = (r_state == ST_OWAIT);
    assign w_accept    = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_lev   = r_lev;
        n_term  = r_term;
        o_cmd          = '0;
        o_cmd.idx      = r_idx;
        o_cmd.raddr    = r_idx;
        o_cmd.lev      = r_lev;
        o_cmd.term     = r_term;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_func == nbe_pkg::FUNC_LOAD) begin
                        o_cmd.wr_weight = 1'b1;
                    end else begin
                        o_cmd.lat_t   = 1'b1;
                        o_cmd.sum_clr = 1'b1;
                        n_idx   = '0;
                        n_state = ST_IND;
                    end
                end
            end
            ST_IND: begin
                o_cmd.ind_wr = 1'b1;
                if (r_idx == w_m - nbe_pkg::CNT_W'(1)) begin
                    n_idx   = '0;
                    n_lev   = nbe_pkg::ORD_W'(1);
                    n_state = ST_RA;
                end else begin
                    n_idx = r_idx + nbe_pkg::CNT_W'(1);
                end
            end
            ST_RA: begin
                n_state = ST_RB;
            end
            ST_RB: begin
                o_cmd.raddr = r_idx + nbe_pkg::CNT_W'(1);
                o_cmd.lat_a = 1'b1;
                n_state     = ST_LB;
            end
            ST_LB: begin
                o_cmd.lat_b   = 1'b1;
                o_cmd.acc_clr = 1'b1;
                n_term        = 1'b0;
                n_state       = ST_MUL;
            end
            ST_MUL: begin
                o_cmd.mul_rec = 1'b1;
                n_state       = ST_DIVS;
            end
            ST_DIVS: begin
                if (i_sts.term_ok) begin
                    o_cmd.div_rec = 1'b1;
                    n_state       = ST_DIVW;
                end else if (!r_term) begin
                    n_term  = 1'b1;
                    n_state = ST_MUL;
                end else begin
                    n_state = ST_WR;
                end
            end
            ST_DIVW: begin
                if (i_sts.div_done) begin
                    o_cmd.acc_add = 1'b1;
                    if (!r_term) begin
                        n_term  = 1'b1;
                        n_state = ST_MUL;
                    end else begin
                        n_state = ST_WR;
                    end
                end
            end
            ST_WR: begin
                o_cmd.wr_work = 1'b1;
                if (({1'b0, r_idx} + 7'(r_lev) + 7'd1) < {1'b0, w_m}) begin
                    n_idx   = r_idx + nbe_pkg::CNT_W'(1);
                    n_state = ST_RA;
                end else if ((r_lev + nbe_pkg::ORD_W'(1)) < w_k) begin
                    n_idx   = '0;
                    n_lev   = r_lev + nbe_pkg::ORD_W'(1);
                    n_state = ST_RA;
                end else begin
                    n_idx   = '0;
                    n_state = r_rat ? ST_SRD : ST_ORD;
                end
            end
            ST_SRD: begin
                n_state = ST_SMUL;
            end
            ST_SMUL: begin
                o_cmd.mul_w = 1'b1;
                n_state     = ST_SACC;
            end
            ST_SACC: begin
                o_cmd.sum_add = 1'b1;
                if (r_idx == w_n - nbe_pkg::CNT_W'(1)) begin
                    n_idx   = '0;
                    n_state = ST_ORD;
                end else begin
                    n_idx   = r_idx + nbe_pkg::CNT_W'(1);
                    n_state = ST_SRD;
                end
            end
            ST_ORD: begin
                n_state = ST_OMUL;
            end
            ST_OMUL: begin
                o_cmd.mul_w = 1'b1;
                n_state     = ST_ODIVS;
            end
            ST_ODIVS: begin
                if (r_rat && !i_sts.sum_zero) begin
                    o_cmd.div_frac = 1'b1;
                    n_state        = ST_ODIVW;
                end else begin
                    n_state = ST_OSET;
                end
            end
            ST_ODIVW: begin
                if (i_sts.div_done) begin
                    n_state = ST_OSET;
                end
            end
            ST_OSET: begin
                o_cmd.out_load = 1'b1;
                n_state        = ST_OWAIT;
            end
            ST_OWAIT: begin
                if (i_out_ready) begin
                    if (r_idx == w_n - nbe_pkg::CNT_W'(1)) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_idx   = r_idx + nbe_pkg::CNT_W'(1);
                        n_state = ST_ORD;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
            r_lev   <= '0;
            r_term  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_lev   <= n_lev;
            r_term  <= n_term;
        end
    end

endmodule

// ===== hdl/nurbs_basis_evaluator.sv =====
// ----------------------------------------------------------------------------
// nurbs_basis_evaluator
// B-spline and rational NURBS basis evaluation by the Cox-de Boor recursion.
// ----------------------------------------------------------------------------
// A load item writes one control-point weight. An evaluate item builds the
// degree-zero interval indicators (m = n + k - 1 of them), then raises them
// level by level in m - level recursion steps per level; each step divides
// only those of its two terms whose operand and knot span are not zero, the
// serial divider being the limiting unit. The results then leave one by one;
// in rational mode a weighting pass over all points comes first and each
// value waits for a 16-step division unless the weight sum is zero. No new
// item is taken until the last basis value of an evaluation has been
// accepted. Weights are held in a store that is not cleared, so a rational
// evaluation must only follow loads of all the points it uses.
module nurbs_basis_evaluator (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [nbe_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [nbe_pkg::CFG_DAT_W-1:0]  i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic                           i_func,
    input  logic [nbe_pkg::IDX_W-1:0]      i_point_index,
    input  logic [nbe_pkg::W_W-1:0]        i_point_weight,
    input  logic [nbe_pkg::T_W-1:0]        i_param_t,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [nbe_pkg::IDX_W-1:0]      o_basis_index,
    output logic [nbe_pkg::V_W-1:0]        o_basis_value,
    output logic                           o_last_value
);

    nbe_pkg::t_cfg w_cfg;
    nbe_pkg::t_cmd w_cmd;
    nbe_pkg::t_sts w_sts;

    // The sequencer owns configuration and both handshakes.
    nbe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_func      (i_func),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cfg       (w_cfg),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    // The datapath holds the stores, the arithmetic and the output register.
    nbe_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (w_cfg),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_point_index  (i_point_index),
        .i_point_weight (i_point_weight),
        .i_param_t      (i_param_t),
        .o_basis_index  (o_basis_index),
        .o_basis_value  (o_basis_value),
        .o_last_value   (o_last_value)
    );

endmodule
